[rtl/core/fasthash64_stream_defines.svh]
// ----------------------------------------------------------------------------
// fasthash64_stream assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef FASTHASH64_STREAM_DEFINES_SVH
`define FASTHASH64_STREAM_DEFINES_SVH

// Same-cycle implication
`define FH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fh64_pkg.sv]
// ----------------------------------------------------------------------------
// fh64_pkg
// Constants, item type, sequencer states and mixing helpers for fasthash64.
// ----------------------------------------------------------------------------
package fh64_pkg;

    localparam logic [63:0] FH_M       = 64'h8803_55f2_1e6d_1965;
    localparam logic [63:0] FH_MIXK    = 64'h2127_599b_f432_5c37;
    localparam logic [63:0] SEED_RESET = 64'd42;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned TDATA_W = 104;   // 64 + 4 + 32, padded to bytes

    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

    // One classified word, as queued between front and back
    typedef struct packed {
        logic [WORD_W-1:0] pre;       // masked word, first xor-shift done
        logic [LEN_W-1:0]  msg_len;
        logic              first;
        logic              absorb;    // nonzero byte count
        logic              last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LEN,
        ST_WORD,
        ST_HASH,
        ST_FIN,
        ST_EMIT
    } fsm_state_t;

    // First half of mix: x ^ (x >> 23)
    function automatic logic [63:0] mix_pre(input logic [63:0] x);
        return x ^ (x >> 23);
    endfunction

    // Last half of mix: x ^ (x >> 47)
    function automatic logic [63:0] mix_post(input logic [63:0] x);
        return x ^ (x >> 47);
    endfunction

    // Keep the low bytes named by the count; counts above eight keep all
    function automatic logic [63:0] byte_mask(input logic [COUNT_W-1:0] cnt);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (cnt > COUNT_W'(i))
            begin
                m[8*i +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

[rtl/core/fh64_front.sv]
// ----------------------------------------------------------------------------
// fh64_front
// Accepts input transactions, unpacks and classifies them for the queue.
// ----------------------------------------------------------------------------
module fh64_front (
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [fh64_pkg::TDATA_W-1:0] s_axis_tdata,
    input  logic                         s_axis_tuser,
    input  logic                         s_axis_tlast,
    input  logic                         queue_full,
    output logic                         push,
    output fh64_pkg::item_t              push_item
);
    import fh64_pkg::*;

    logic [WORD_W-1:0]  data_word;
    logic [COUNT_W-1:0] byte_count;
    logic [LEN_W-1:0]   message_length;
    logic [WORD_W-1:0]  masked;

    assign data_word      = s_axis_tdata[WORD_W-1:0];
    assign byte_count     = s_axis_tdata[WORD_W +: COUNT_W];
    assign message_length = s_axis_tdata[WORD_W+COUNT_W +: LEN_W];

    assign masked = data_word & byte_mask(byte_count);

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    always_comb
    begin
        push_item.pre     = mix_pre(masked);
        push_item.msg_len = message_length;
        push_item.first   = s_axis_tuser;
        push_item.absorb  = (byte_count != '0);
        push_item.last    = s_axis_tlast;
    end

endmodule

[rtl/core/fh64_queue.sv]
// ----------------------------------------------------------------------------
// fh64_queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module fh64_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fh64_pkg::item_t push_item,
    input  logic            pop,
    output fh64_pkg::item_t head_item,
    output logic            full,
    output logic            empty
);
    import fh64_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    item_t         slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/fh64_mul.sv]
// ----------------------------------------------------------------------------
// fh64_mul
// Two-stage 64x64 multiplier, low 64 bits, from three 32x32 partials.
// ----------------------------------------------------------------------------
module fh64_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);
    logic [63:0] pl_reg, pl_next;
    logic [31:0] pa_reg, pa_next;
    logic [31:0] pb_reg, pb_next;
    logic [63:0] p_reg, p_next;
    logic        v1_reg, v2_reg;

    assign pl_next = a[31:0] * b[31:0];
    assign pa_next = a[63:32] * b[31:0];
    assign pb_next = a[31:0] * b[63:32];
    assign p_next  = pl_reg + {pa_reg + pb_reg, 32'b0};

    assign done = v2_reg;
    assign p    = p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pl_reg <= pl_next;
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (v1_reg)
        begin
            p_reg <= p_next;
        end
    end

endmodule

[rtl/core/fh64_back.sv]
// ----------------------------------------------------------------------------
// fh64_back
// Sequencer: seeds, absorbs and finalises the running hash, one item at a time.
// ----------------------------------------------------------------------------
module fh64_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [63:0]     cfg_wr_data,
    input  logic            queue_empty,
    input  fh64_pkg::item_t head_item,
    output logic            pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [63:0]     m_axis_tdata
);
    import fh64_pkg::*;

    fsm_state_t  state_reg, state_next;
    item_t       cur_reg, cur_next;
    logic [63:0] hash_reg, hash_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] seed_reg;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;

    logic        mul_start;
    logic [63:0] mul_a, mul_b;
    logic        mul_done;
    logic [63:0] mul_p;

    fh64_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        hash_next      = hash_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        mul_start      = 1'b0;
        mul_a          = mix_pre(hash_reg);
        mul_b          = FH_MIXK;

        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    cur_next   = head_item;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (cur_reg.first)
                begin
                    mul_start  = 1'b1;
                    mul_a      = {32'b0, cur_reg.msg_len};
                    mul_b      = FH_M;
                    state_next = ST_LEN;
                end
                else if (cur_reg.absorb)
                begin
                    mul_start  = 1'b1;
                    mul_a      = cur_reg.pre;
                    mul_b      = FH_MIXK;
                    state_next = ST_WORD;
                end
                else if (cur_reg.last)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mix_pre(hash_reg);
                    mul_b      = FH_MIXK;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LEN:
            begin
                if (mul_done)
                begin
                    hash_next     = seed_reg ^ mul_p;
                    cur_next.first = 1'b0;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_WORD:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = hash_reg ^ mix_post(mul_p);
                    mul_b      = FH_M;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (mul_done)
                begin
                    hash_next       = mul_p;
                    cur_next.absorb = 1'b0;
                    state_next      = ST_DISPATCH;
                end
            end
            ST_FIN:
            begin
                if (mul_done)
                begin
                    res_next   = mix_post(mul_p);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= '0;
            seed_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

[rtl/core/fasthash64_stream.sv]
// ----------------------------------------------------------------------------
// fasthash64_stream
// Streaming fasthash64 over little-endian 64-bit message words.
// ----------------------------------------------------------------------------
// A message enters as one transaction per 64-bit word; the word flagged on
// tuser opens it and seeds the hash with seed ^ (length * m), the word
// flagged on tlast closes it and yields exactly one output transaction with
// the 64-bit hash. Items are handled one at a time by a sequencer that runs
// every 64-bit product through one shared two-stage multiplier: an opening
// word adds one product for the length, a word with a nonzero count two,
// a closing word one more for the finaliser, and an empty word none.
// A small queue in front of the sequencer lets the source run ahead by
// QUEUE_DEPTH items, and the output register lets the next item proceed
// while a finished hash waits to be taken. The seed may only be written
// while the block is idle; it resets to 42.
// ----------------------------------------------------------------------------
module fasthash64_stream #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,

    // Seed register write
    input  logic                         cfg_wr_en,
    input  logic [63:0]                  cfg_wr_data,

    // Input words
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [63:0] data_word, [67:64] byte_count, [99:68] message_length, pad zero
    input  logic [fh64_pkg::TDATA_W-1:0] s_axis_tdata,
    // [0] first_word
    input  logic                         s_axis_tuser,
    // last_word
    input  logic                         s_axis_tlast,

    // Hash results
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [63:0] hash_value
    output logic [63:0]                  m_axis_tdata
);
    import fh64_pkg::*;

    logic  queue_full;
    logic  queue_empty;
    logic  push;
    logic  pop;
    item_t push_item;
    item_t head_item;

    // Front: unpack, clamp and mask, pre-shift the word
    fh64_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    // Decoupling queue
    fh64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // Back: hash recurrence, finalisation and output register
    fh64_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .queue_empty   (queue_empty),
        .head_item     (head_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[rtl/core/fh64_checker.sv]
// ----------------------------------------------------------------------------
// fh64_checker
// Port-level checks on fasthash64_stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "fasthash64_stream_defines.svh"

module fh64_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    // Closing words taken minus hashes delivered
    logic [7:0] pend_reg, pend_next;
    logic       last_acc;
    logic       out_acc;

    assign last_acc  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign out_acc   = m_axis_tvalid && m_axis_tready;
    assign pend_next = pend_reg + {7'b0, last_acc} - {7'b0, out_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `FH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
    `FH_ASSERT_SAME(a_no_spurious, m_axis_tvalid,
        pend_reg != 8'd0, "hash offered with no closing word taken")
    `FH_ASSERT_NEXT(a_single_result, out_acc && (pend_reg == 8'd1),
        !m_axis_tvalid, "hash repeated after last one delivered")

endmodule

bind fasthash64_stream fh64_checker u_fh64_checker (.*);

[bench/tb_fasthash64_stream.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fasthash64_stream
// Self-checking bench for the streaming fasthash64 block. Message words are
// driven on the input stream and every accepted word updates a local copy of
// the running hash. Each closing word queues the hash it should produce.
// Hashes taken from the output stream are compared in order against that
// queue. Both streams idle at random, with one phase where neither idles,
// and the seed register is moved through its extremes and random values
// between phases.
// ----------------------------------------------------------------------------
module tb_fasthash64_stream;

    import fh64_pkg::*;

    // Cycles with no transaction on either stream before the run is abandoned
    localparam int unsigned STALL_LIMIT  = 2000;
    // Worst-case drain: two queued words, one in the sequencer and one parked
    // in the output register, plus margin
    localparam int unsigned SETTLE_CYCLES = 80;

    // One input word as the bench sees it
    typedef struct {
        logic [63:0] word;
        logic [3:0]  count;
        logic        first;
        logic        last;
        logic [31:0] length;
    } msg_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [63:0]          cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [63:0]          m_axis_tdata;

    // Local copy of the block's state and its seed register
    logic [63:0]          seed_shadow;
    logic [63:0]          hash_shadow;

    // Hashes owed by the block, oldest first
    logic [63:0]          pending_hashes[$];

    int unsigned          error_count;
    int unsigned          words_sent;

    // Percentage of cycles in which each side holds back
    int unsigned          src_gap_pct;
    int unsigned          sink_gap_pct;

    fasthash64_stream i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Hash arithmetic, all modulo 2^64
    // ------------------------------------------------------------------------

    // xor-shift, multiply, xor-shift finaliser
    function automatic logic [63:0] avalanche(input logic [63:0] x);
        logic [63:0] y;
        y = x ^ (x >> 23);
        y = y * FH_MIXK;
        return y ^ (y >> 47);
    endfunction

    // Advance the local hash by one accepted word; a closing word owes a hash
    function automatic void absorb_word(input msg_word_t w);
        logic [63:0] keep;
        if (w.first)
        begin
            hash_shadow = seed_shadow ^ (64'(w.length) * FH_M);
        end
        // A zero count absorbs nothing; counts of eight and above take the
        // whole word
        if (w.count != 4'd0)
        begin
            if (w.count >= 4'd8)
            begin
                keep = '1;
            end
            else
            begin
                keep = (64'd1 << (8 * w.count)) - 64'd1;
            end
            hash_shadow = (hash_shadow ^ avalanche(w.word & keep)) * FH_M;
        end
        // The hash is not cleared after a closing word
        if (w.last)
        begin
            pending_hashes.push_back(avalanche(hash_shadow));
        end
    endfunction

    function automatic msg_word_t make_word(input logic [63:0] word,
                                            input logic [3:0]  count,
                                            input logic        first,
                                            input logic        last,
                                            input logic [31:0] length);
        msg_word_t w;
        w.word   = word;
        w.count  = count;
        w.first  = first;
        w.last   = last;
        w.length = length;
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Called and returning at a rising edge; tvalid stays high
    // after the transaction so that back-to-back words run without a gap.
    // ------------------------------------------------------------------------
    task automatic send_word(input msg_word_t w);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        // tdata: [63:0] data_word, [67:64] byte_count, [99:68] message_length
        s_axis_tdata  <= {4'b0, w.length, w.count, w.word};
        s_axis_tuser  <= w.first;
        s_axis_tlast  <= w.last;
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        absorb_word(w);
        words_sent++;
    endtask

    // Well-formed message of nbytes bytes, optionally with a false length
    // field or with random counts on the inner words
    task automatic send_message(input int unsigned nbytes,
                                input bit          false_length,
                                input bit          ragged);
        int unsigned n_words;
        logic [31:0] len_field;
        msg_word_t   w;
        n_words   = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
        len_field = false_length ? $urandom : nbytes;
        for (int unsigned i = 0; i < n_words; i++)
        begin
            w.word  = rand64();   // bytes beyond the count must be masked off
            w.first = (i == 0);
            w.last  = (i == n_words - 1);
            // length is only read on the opening word; junk elsewhere
            w.length = w.first ? len_field : $urandom;
            if (nbytes == 0)
            begin
                w.count = 4'd0;
            end
            else if (w.last && (nbytes % 8) != 0)
            begin
                w.count = 4'(nbytes % 8);
            end
            else
            begin
                w.count = 4'd8;
            end
            if (ragged && !w.last)
            begin
                w.count = 4'($urandom_range(15));
            end
            send_word(w);
        end
    endtask

    // Words with every field random, flags included
    task automatic send_noise(input int unsigned n);
        repeat (n)
        begin
            send_word(make_word(rand64(), 4'($urandom_range(15)), 1'($urandom),
                                1'($urandom), $urandom));
        end
    endtask

    // Mostly short messages, now and then a longer one
    function automatic int unsigned pick_length();
        if ($urandom_range(19) == 0)
        begin
            return $urandom_range(64, 200);
        end
        return $urandom_range(0, 40);
    endfunction

    // Source holds off until the block has delivered everything owed; it idles
    // even when nothing is owed
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_hashes.size() != 0);
    endtask

    // Seed write, only with the block idle. Words that owe no hash may still
    // be in the sequencer after the last hash, hence the settle time.
    task automatic load_seed(input logic [63:0] value);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        seed_shadow = value;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random backpressure and in-order comparison
    // ------------------------------------------------------------------------
    initial
    begin : hash_checker
        logic [63:0] want;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_hashes.size() == 0)
                begin
                    $display("%0t: unexpected hash, expected none, actual %h",
                             $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_hashes.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $display("%0t: hash mismatch, expected %h, actual %h",
                                 $time, want, m_axis_tdata);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= rst_n && ($urandom_range(99) >= sink_gap_pct);
        end
    end

    // Abandon the run once neither stream has moved for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner cases under the reset seed
    task automatic test_directed();
        // Closing word with no opening word: absorbed into the reset hash
        send_word(make_word('1, 4'd8, 1'b0, 1'b1, 32'd0));
        // Empty message
        send_word(make_word(rand64(), 4'd0, 1'b1, 1'b1, 32'd0));
        // Open and close on one word, largest length
        send_word(make_word(64'd0, 4'd8, 1'b1, 1'b1, 32'hffff_ffff));
        // Counts above eight take the whole word
        send_word(make_word(rand64(), 4'd15, 1'b1, 1'b1, 32'd8));
        send_word(make_word('1, 4'd9, 1'b1, 1'b1, 32'd8));
        // Single and seven byte tails
        send_word(make_word('1, 4'd1, 1'b1, 1'b1, 32'd1));
        send_word(make_word('1, 4'd7, 1'b1, 1'b1, 32'd7));
        // Short word in mid-message, length field disagreeing with counts
        send_word(make_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd21));
        send_word(make_word(rand64(), 4'd3, 1'b0, 1'b0, 32'd21));
        send_word(make_word(rand64(), 4'd8, 1'b0, 1'b0, 32'd21));
        send_word(make_word(rand64(), 4'd5, 1'b0, 1'b1, 32'd21));
        // Closing word with zero count
        send_word(make_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd8));
        send_word(make_word(rand64(), 4'd0, 1'b0, 1'b1, 32'd8));
        // Continues from the hash left by the previous message
        send_word(make_word(rand64(), 4'd4, 1'b0, 1'b1, 32'd0));
        // Reopened message discards the partial hash
        send_word(make_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd16));
        send_word(make_word(rand64(), 4'd8, 1'b1, 1'b1, 32'd16));
        hold_until_drained();
        // Top length bit alone, then an unflagged word ahead of a closing one
        send_word(make_word(rand64(), 4'd8, 1'b1, 1'b1, 32'h8000_0000));
        send_word(make_word(rand64(), 4'd8, 1'b0, 1'b0, $urandom));
        send_word(make_word(rand64(), 4'd0, 1'b0, 1'b1, $urandom));
    endtask

    // Seed at all zeros and at all ones
    task automatic test_seed_extremes();
        load_seed(64'd0);
        repeat (25) send_message(pick_length(), 1'b0, 1'b0);
        load_seed('1);
        repeat (25) send_message(pick_length(), 1'b0, 1'b0);
    endtask

    // Mostly clean messages, some with false lengths or ragged counts, and
    // scattered noise words
    task automatic test_random_traffic(input logic [63:0] seed_value,
                                       input int unsigned word_target);
        int unsigned pick;
        load_seed(seed_value);
        while (words_sent < word_target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                send_message(pick_length(), 1'b0, 1'b0);
            end
            else if (pick < 80)
            begin
                send_message(pick_length(), 1'b1, 1'b0);
            end
            else if (pick < 88)
            begin
                send_message(pick_length(), 1'b0, 1'b1);
            end
            else
            begin
                send_noise($urandom_range(1, 3));
            end
            if ($urandom_range(49) == 0)
            begin
                hold_until_drained();
            end
        end
    endtask

    // Neither side idles: block runs at its own pace throughout
    task automatic test_back_to_back(input int unsigned word_target);
        src_gap_pct  = 0;
        sink_gap_pct = 0;
        load_seed(rand64());
        while (words_sent < word_target)
        begin
            send_message(pick_length(), 1'b0, 1'b0);
        end
        src_gap_pct  = 24;
        sink_gap_pct = 24;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        seed_shadow   = SEED_RESET;
        hash_shadow   = '0;
        error_count   = 0;
        words_sent    = 0;
        src_gap_pct   = 24;
        sink_gap_pct  = 24;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_seed_extremes();
        test_random_traffic(rand64(), 450);
        test_back_to_back(words_sent + 150);
        test_random_traffic(rand64(), 850);

        // Let the last hashes through, then allow for anything stray
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_hashes.size() != 0)
        begin
            $display("%0t: %0d expected hashes never arrived", $time, pending_hashes.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
